// ----- sv/sksr_pkg.sv -----
// Shared types and constants for the keyed stack with search and remove.
// Used by sksr_cell and stack_with_key_search_remove; depends on nothing.
package sksr_pkg;

  localparam int KEY_W       = 64;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 4;
  localparam int DEPTH_DEF   = 8;
  localparam int MAX_RESULTS = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_REMOVE  = 3'd2,
    FN_SEARCH  = 3'd3,
    FN_COUNT   = 3'd4,
    FN_DISPLAY = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // What every cell of the chain does
  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_PUSH   = 3'd1,
    CM_POP    = 3'd2,
    CM_REMOVE = 3'd3,
    CM_ROTATE = 3'd4
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

endpackage

// ----- sv/stack_with_key_search_remove.sv -----
// Bounded stack of 64-bit keys with search and in-place remove.
// Holds a chain of sksr_cell slots and the control; uses sksr_pkg.
//
// Usage: drive in_func and in_key_in and raise start; the word is taken on a
// clock edge where start is high and busy is low. Slot 0 of the chain is the
// top of the stack. Push, pop, remove, search and count finish in the cycle
// they are taken: their single result appears on the out_ ports in the cycle
// after, marked by out_valid for exactly one cycle, with out_last high.
// A new word may be taken on every cycle for these operations.
// Display on a non-empty stack rotates the occupied slots once around, one
// slot per cycle, so it holds busy until every occupied slot has moved and emits
// one result per cycle (top first, at most MAX_RESULTS of them), the first in
// the cycle after the one in which a single result would appear; the rotation
// leaves the stack as it was. Display on an empty stack gives a
// single empty-status result like the other operations.
// Results cannot be held off: the receiver must take each one in its cycle.
// Reset (rst_n low, synchronous) empties the stack and ends any display;
// key slots are not cleared and are only read below the fill level.
module stack_with_key_search_remove #(
  parameter int DEPTH = sksr_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sksr_pkg::FUNC_W-1:0]   in_func,
  input  logic [sksr_pkg::KEY_W-1:0]    in_key_in,
  output logic                          out_valid,
  output logic [sksr_pkg::STATUS_W-1:0] out_status,
  output logic [sksr_pkg::KEY_W-1:0]    out_key_out,
  output logic [sksr_pkg::OCC_W-1:0]    out_occupancy,
  output logic                          out_last
);
  import sksr_pkg::*;

  localparam int FILL_W = $clog2(DEPTH+1);

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [OCC_W-1:0]    out_occ_r;
  logic                out_last_r, out_last_nxt;

  cell_mode_t          mode;
  logic [KEY_W-1:0]    keys [DEPTH];
  logic [DEPTH:0]      seen;
  logic                accept;
  logic                hit;
  logic [31:0]         fill32, k32, shown;

  assign seen[0] = 1'b0;
  assign hit     = seen[DEPTH];
  assign busy    = (state_r == S_DISP);
  assign accept  = start && !busy;
  assign fill32  = 32'(fill_r);
  assign k32     = 32'(k_r);
  assign shown   = (fill32 > 32'(MAX_RESULTS)) ? 32'(MAX_RESULTS) : fill32;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_k, next_k;
    if (i == 0) begin : g_top
      assign prev_k = in_key_in;
    end else begin : g_mid
      assign prev_k = keys[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign next_k = keys[i];
    end else begin : g_up
      assign next_k = keys[i+1];
    end
    sksr_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .mode     (mode),
      .fill     (fill_r),
      .key_in   (in_key_in),
      .prev_key (prev_k),
      .next_key (next_k),
      .head_key (keys[0]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .key_q    (keys[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    mode           = CM_HOLD;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_DONE;
    out_key_nxt    = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_func)
            FN_PUSH: begin
              if (fill_r == FILL_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                mode     = CM_PUSH;
                fill_nxt = fill_r + 1'b1;
              end
            end
            FN_POP: begin
              if (fill_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                mode        = CM_POP;
                out_key_nxt = keys[0];
                fill_nxt    = fill_r - 1'b1;
              end
            end
            FN_REMOVE: begin
              if (hit) begin
                mode     = CM_REMOVE;
                fill_nxt = fill_r - 1'b1;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            FN_SEARCH: out_status_nxt = hit ? ST_DONE : ST_NOTFOUND;
            FN_COUNT:  out_status_nxt = ST_DONE;
            FN_DISPLAY: begin
              if (fill_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_DISP;
                k_nxt         = '0;
              end
            end
            default:   out_status_nxt = ST_DONE;
          endcase
        end
      end
      S_DISP: begin
        // emit the top (up to MAX_RESULTS words), rotate the occupied slots by one
        mode          = CM_ROTATE;
        out_valid_nxt = k32 < 32'(MAX_RESULTS);
        out_key_nxt   = keys[0];
        out_last_nxt  = (k32 + 32'd1 == shown);
        k_nxt         = k_r + 1'b1;
        if (k32 + 32'd1 == fill32) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_occ_r    <= OCC_W'(fill_nxt);
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill level above depth");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> fill_r == FILL_W'(DEPTH))
    else $error("push refused while stack not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> fill_r == '0)
    else $error("empty status with entries stored");

  a_disp_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP && k32 + 32'd1 == fill32 |=> state_r == S_IDLE)
    else $error("display did not end after last slot");

  a_disp_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("display burst broken before last word");

endmodule

// ----- sv/sksr_cell.sv -----
// One slot of the stack chain: holds a key, compares it with the search key and takes
// a neighbor's, the pushed or the top key on push, pop, remove or display rotation. Uses sksr_pkg.
module sksr_cell #(
  parameter int DEPTH = sksr_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  sksr_pkg::cell_mode_t       mode,
  input  logic [$clog2(DEPTH+1)-1:0] fill,
  input  logic [sksr_pkg::KEY_W-1:0] key_in,
  input  logic [sksr_pkg::KEY_W-1:0] prev_key,
  input  logic [sksr_pkg::KEY_W-1:0] next_key,
  input  logic [sksr_pkg::KEY_W-1:0] head_key,
  input  logic                       seen_in,
  output logic                       seen_out,
  output logic [sksr_pkg::KEY_W-1:0] key_q
);
  import sksr_pkg::*;

  localparam int FILL_W = $clog2(DEPTH+1);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             occupied;
  logic             match;

  assign occupied = FILL_W'(IDX) < fill;
  assign match    = occupied && (key_r == key_in);
  // a hit here or above pulls this slot and all below it up by one
  assign seen_out = seen_in | match;
  assign key_q    = key_r;

  always_comb begin
    key_nxt = key_r;
    case (mode)
      CM_HOLD:   key_nxt = key_r;
      CM_PUSH:   key_nxt = prev_key;
      CM_POP:    key_nxt = next_key;
      CM_REMOVE: key_nxt = seen_out ? next_key : key_r;
      CM_ROTATE: begin
        if (FILL_W'(IDX + 1) == fill) begin
          key_nxt = head_key;
        end else if (FILL_W'(IDX + 1) < fill) begin
          key_nxt = next_key;
        end
      end
      default:   key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- tb/stack_with_key_search_remove_tb.sv -----
// Self-checking testbench for the keyed stack with search and remove.
// Predicts every result word from its own stack copy; needs sksr_pkg and the RTL.
module stack_with_key_search_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sksr_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [OCC_W-1:0]    occ;
    logic                last;
  } stack_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [KEY_W-1:0]    in_key_in = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key_out;
  logic [OCC_W-1:0]    out_occupancy;
  logic                out_last;

  // Shadow copy of the stack; index 0 is the bottom entry
  logic [KEY_W-1:0] shadow_keys [STACK_DEPTH];
  int               shadow_fill = 0;
  stack_result_t    pending_results [$];
  int               mismatches = 0;
  int               idle_cycles = 0;

  stack_with_key_search_remove #(.DEPTH(STACK_DEPTH)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_key_in     (in_key_in),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key_out   (out_key_out),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_pending(input logic [STATUS_W-1:0] st,
                                       input logic [KEY_W-1:0] key, input logic last);
    stack_result_t r;
    r.status = st;
    r.key    = key;
    r.occ    = shadow_fill[OCC_W-1:0];
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_stack_op(input logic [FUNC_W-1:0] fn,
                                           input logic [KEY_W-1:0] key);
    int  pos;
    bit  hit;
    int  shown;
    pos = 0;
    hit = 1'b0;
    case (fn)
      FN_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          push_pending(ST_FULL, KEY_ZERO, 1'b1);
        end else begin
          shadow_keys[shadow_fill] = key;
          shadow_fill++;
          push_pending(ST_DONE, KEY_ZERO, 1'b1);
        end
      end
      FN_POP: begin
        if (shadow_fill == 0) begin
          push_pending(ST_EMPTY, KEY_ZERO, 1'b1);
        end else begin
          shadow_fill--;
          push_pending(ST_DONE, shadow_keys[shadow_fill], 1'b1);
        end
      end
      FN_REMOVE: begin
        // Match nearest the top wins; entries above it shift down
        for (int i = shadow_fill - 1; i >= 0; i--) begin
          if (!hit && shadow_keys[i] == key) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) begin
          for (int i = pos; i + 1 < shadow_fill; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_fill--;
          push_pending(ST_DONE, KEY_ZERO, 1'b1);
        end else begin
          push_pending(ST_NOTFOUND, KEY_ZERO, 1'b1);
        end
      end
      FN_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) if (shadow_keys[i] == key) hit = 1'b1;
        push_pending(hit ? ST_DONE : ST_NOTFOUND, KEY_ZERO, 1'b1);
      end
      FN_COUNT: push_pending(ST_DONE, KEY_ZERO, 1'b1);
      FN_DISPLAY: begin
        if (shadow_fill == 0) begin
          push_pending(ST_EMPTY, KEY_ZERO, 1'b1);
        end else begin
          shown = (shadow_fill > MAX_RESULTS) ? MAX_RESULTS : shadow_fill;
          for (int k = 0; k < shown; k++)
            push_pending(ST_DONE, shadow_keys[shadow_fill - 1 - k], k == shown - 1);
        end
      end
      default: push_pending(ST_DONE, KEY_ZERO, 1'b1);
    endcase
  endfunction

  // Call at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                           input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start     <= 1'b1;
    in_func   <= fn;
    in_key_in <= key;
    do @(posedge clk); while (busy);
    predict_stack_op(fn, key);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return KEY_ZERO;
      1: return KEY_ONES;
      2: return 64'h0123_4567_89AB_CDEF;
      3: return 64'h5555_5555_5555_5555;
      4: return 64'hAAAA_AAAA_AAAA_AAAA;
      default: return 64'h0000_0000_0000_0042;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return FN_PUSH;
    if (roll < 50) return FN_POP;
    if (roll < 65) return FN_REMOVE;
    if (roll < 80) return FN_SEARCH;
    if (roll < 87) return FN_COUNT;
    if (roll < 97) return FN_DISPLAY;
    return (roll < 99) ? FN_SPARE_6 : FN_SPARE_7;
  endfunction

  task automatic test_empty_stack();
    send_word(FN_POP, KEY_ZERO, 1'b0);
    send_word(FN_DISPLAY, KEY_ZERO, 1'b0);
    send_word(FN_SEARCH, KEY_ZERO, 1'b0);
    send_word(FN_REMOVE, KEY_ONES, 1'b0);
    send_word(FN_COUNT, KEY_ONES, 1'b0);
    send_word(FN_SPARE_6, KEY_ONES, 1'b0);
    send_word(FN_SPARE_7, KEY_ZERO, 1'b0);
  endtask

  task automatic test_push_until_full();
    send_word(FN_PUSH, KEY_ZERO, 1'b0);
    send_word(FN_PUSH, KEY_ONES, 1'b0);
    send_word(FN_PUSH, 64'h5555_5555_5555_5555, 1'b0);
    send_word(FN_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(FN_PUSH, 64'h0000_0000_0000_1234, 1'b0);
    send_word(FN_PUSH, 64'h8000_0000_0000_0001, 1'b0);
    send_word(FN_PUSH, 64'h0000_0000_0000_1234, 1'b0);
    send_word(FN_PUSH, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_word(FN_PUSH, 64'hDEAD_BEEF_0000_0000, 1'b0);
    send_word(FN_DISPLAY, KEY_ZERO, 1'b0);
  endtask

  task automatic test_search_and_remove();
    send_word(FN_SEARCH, KEY_ONES, 1'b0);
    send_word(FN_SEARCH, 64'h0000_0000_0000_0042, 1'b0);
    // Duplicate key: only the copy nearest the top goes
    send_word(FN_REMOVE, 64'h0000_0000_0000_1234, 1'b0);
    send_word(FN_REMOVE, KEY_ZERO, 1'b0);
    send_word(FN_REMOVE, 64'hDEAD_BEEF_0000_0000, 1'b0);
    send_word(FN_DISPLAY, KEY_ZERO, 1'b0);
    send_word(FN_POP, KEY_ZERO, 1'b0);
    send_word(FN_COUNT, KEY_ZERO, 1'b0);
  endtask

  task automatic test_random_traffic(input int words, input bit allow_idle);
    for (int n = 0; n < words; n++) send_word(pick_func(), pick_key(), allow_idle);
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    send_word(FN_DISPLAY, KEY_ZERO, 1'b0);
    send_word(FN_COUNT, KEY_ZERO, 1'b0);
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: status=%0d key=%h occ=%0d last=%0d",
                   out_status, out_key_out, out_occupancy, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_key_out !== want.key ||
            out_occupancy !== want.occ || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp status=%0d key=%h occ=%0d last=%0d, got status=%0d key=%h occ=%0d last=%0d",
                     want.status, want.key, want.occ, want.last,
                     out_status, out_key_out, out_occupancy, out_last);
        end
      end
    end
  end

  // Watchdog: stop when no word moves on either side for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_stack();
    test_push_until_full();
    test_search_and_remove();
    test_random_traffic(120, 1'b1);
    test_drain_pause();
    test_random_traffic(90, 1'b1);
    test_random_traffic(50, 1'b0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 4) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
